// ===== hw/rtl/lph_pkg.sv =====
package lph_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int KEY_W = 31;
	localparam int POS_W = 4;
	localparam int STAT_W = 2;
	localparam int UPC_W = 3;
	localparam int COND_W = 3;

	// operation codes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// result codes
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// microprogram step addresses
	localparam logic [UPC_W-1:0] U_IDLE = 3'd0;
	localparam logic [UPC_W-1:0] U_HOME = 3'd1;
	localparam logic [UPC_W-1:0] U_PROBE = 3'd2;
	localparam logic [UPC_W-1:0] U_RESULT = 3'd3;
	localparam logic [UPC_W-1:0] U_CLEAR = 3'd4;

	// jump conditions: jump to target when true, else hold the step
	localparam logic [COND_W-1:0] C_ACCEPT = 3'd0;
	localparam logic [COND_W-1:0] C_HOME_DONE = 3'd1;
	localparam logic [COND_W-1:0] C_PROBE_DONE = 3'd2;
	localparam logic [COND_W-1:0] C_OUT_FREE = 3'd3;
	localparam logic [COND_W-1:0] C_CLEAR_LAST = 3'd4;

	typedef struct packed {
		logic in_rdy;
		logic home_run;
		logic probe;
		logic res_load;
		logic clear;
		logic [COND_W-1:0] cond;
		logic [UPC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic home_done;
		logic probe_done;
		logic out_free;
		logic clear_last;
	} seq_flags_t;

endpackage

// ===== hw/rtl/lph_seq.sv =====
module lph_seq
	import lph_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input seq_flags_t flags,
	output ctrl_word_t cw
);

	logic [UPC_W-1:0] upc_q;
	logic jump;

	// control store
	always_comb begin
		cw = '0;
		case (upc_q)
			U_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.cond = C_ACCEPT;
				cw.target = U_HOME;
			end
			U_HOME: begin
				cw.home_run = 1'b1;
				cw.cond = C_HOME_DONE;
				cw.target = U_PROBE;
			end
			U_PROBE: begin
				cw.probe = 1'b1;
				cw.cond = C_PROBE_DONE;
				cw.target = U_RESULT;
			end
			U_RESULT: begin
				cw.res_load = 1'b1;
				cw.cond = C_OUT_FREE;
				cw.target = U_IDLE;
			end
			U_CLEAR: begin
				cw.clear = 1'b1;
				cw.cond = C_CLEAR_LAST;
				cw.target = U_IDLE;
			end
			default: begin
				cw.cond = C_ACCEPT;
				cw.target = U_IDLE;
				cw.in_rdy = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (cw.cond)
			C_ACCEPT: jump = flags.in_valid;
			C_HOME_DONE: jump = flags.home_done;
			C_PROBE_DONE: jump = flags.probe_done;
			C_OUT_FREE: jump = flags.out_free;
			C_CLEAR_LAST: jump = flags.clear_last;
			default: jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLEAR;
		end else if (jump) begin
			upc_q <= cw.target;
		end
	end

endmodule

// ===== hw/rtl/lph_home.sv =====
module lph_home
	import lph_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic run,
	input logic [KEY_W-1:0] key,
	output logic done,
	output logic [$clog2(SLOT_COUNT)-1:0] home
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam bit IS_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
	// floor(key / N) = (key * RECIP) >> SH for every 31-bit key
	localparam int SH = KEY_W + IDX_W;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'(SLOT_COUNT) + 64'd1;
	localparam logic [31:0] RECIP = RECIP_FULL[31:0];
	localparam logic [IDX_W-1:0] MOD_LO = IDX_W'(SLOT_COUNT);
	localparam logic [1:0] STEPS = 2'd2;

	logic [KEY_W-1:0] key_q;
	logic [KEY_W+31:0] prod_q;
	logic [KEY_W-1:0] quot;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] rem_nx;
	logic [1:0] cnt_q;

	// remainder is below N, so the low bits of key - q * N are enough
	assign quot = KEY_W'(prod_q >> SH);
	assign rem_nx = key_q[IDX_W-1:0] - quot[IDX_W-1:0] * MOD_LO;

	assign done = IS_POW2 ? 1'b1 : (cnt_q == STEPS);
	assign home = IS_POW2 ? key_q[IDX_W-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (run && !done) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	// step 0: reciprocal multiply, step 1: subtract
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end else if (run && !done) begin
			if (cnt_q == '0) begin
				prod_q <= key_q * RECIP;
			end else begin
				rem_q <= rem_nx;
			end
		end
	end

endmodule

// ===== hw/rtl/lph_dp.sv =====
module lph_dp
	import lph_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input ctrl_word_t cw,
	input logic accept,
	input logic mode,
	input logic [KEY_W-1:0] key,
	input logic [$clog2(SLOT_COUNT)-1:0] home,
	output logic probe_done,
	output logic clear_last,
	output logic [STAT_W-1:0] res_status,
	output logic [POS_W-1:0] res_position
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int WORD_W = KEY_W + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

	// slot word: {used, key}
	logic [WORD_W-1:0] mem [SLOT_COUNT];

	logic mode_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] addr_nx;
	logic [IDX_W-1:0] n_q;
	logic rd_v_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [WORD_W-1:0] rd_data_s1;
	logic [STAT_W-1:0] res_status_q;
	logic [POS_W-1:0] res_position_q;

	logic used;
	logic match;
	logic empty_hit;
	logic key_hit;
	logic exhausted;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign addr_nx = (addr_q == LAST) ? '0 : addr_q + 1'b1;

	assign used = rd_data_s1[WORD_W-1];
	assign match = (rd_data_s1[KEY_W-1:0] == key_q);
	assign empty_hit = rd_v_s1 && !used;
	assign key_hit = rd_v_s1 && used && match && (mode_q == MODE_SEARCH);
	assign exhausted = rd_v_s1 && (n_q == LAST);
	assign probe_done = cw.probe && (empty_hit || key_hit || exhausted);
	assign clear_last = (addr_q == LAST);

	// single write port: clearing pass or insert into the first empty slot
	always_comb begin
		wr_en = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		if (cw.clear) begin
			wr_en = 1'b1;
		end else if (cw.probe && empty_hit && (mode_q == MODE_INSERT)) begin
			wr_en = 1'b1;
			wr_addr = addr_s1;
			wr_data = {1'b1, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[addr_q];
		addr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			n_q <= '0;
			rd_v_s1 <= 1'b0;
		end else if (cw.clear) begin
			addr_q <= addr_nx;
		end else if (cw.home_run) begin
			addr_q <= home;
			n_q <= '0;
			rd_v_s1 <= 1'b0;
		end else if (cw.probe) begin
			addr_q <= addr_nx;
			rd_v_s1 <= 1'b1;
			if (rd_v_s1) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q <= key;
		end
		if (probe_done) begin
			if (empty_hit && (mode_q == MODE_INSERT)) begin
				res_status_q <= ST_INSERTED;
				res_position_q <= POS_W'(addr_s1);
			end else if (key_hit) begin
				res_status_q <= ST_FOUND;
				res_position_q <= POS_W'(addr_s1);
			end else if (mode_q == MODE_INSERT) begin
				res_status_q <= ST_FULL;
				res_position_q <= '0;
			end else begin
				res_status_q <= ST_NOT_FOUND;
				res_position_q <= '0;
			end
		end
	end

	assign res_status = res_status_q;
	assign res_position = res_position_q;

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Open-addressed hash table with linear probing over SLOT_COUNT slots. Each input
// transfer is an insert (mode 0) or a search (mode 1) of a 31-bit key; each gives
// exactly one output transfer with status (0 inserted, 1 full, 2 found, 3 not found)
// and the low four bits of the slot, 0 on full or not found. Duplicates are stored
// again. After reset the block clears every slot of the slot memory before in_ready
// first rises. Per item: the transfer is taken, the home slot is found (directly from
// the key when SLOT_COUNT is a power of two; otherwise a reciprocal multiply, then a
// subtract), then up to SLOT_COUNT slots are examined (one memory read per cycle),
// and the result is loaded into the output register once that is free. A finished
// result sits in the output register while the next item is taken and worked on.
module linear_probe_hash_table
	import lph_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic mode,
	input logic [KEY_W-1:0] key,
	output logic out_valid,
	input logic out_ready,
	output logic [STAT_W-1:0] status,
	output logic [POS_W-1:0] position
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	ctrl_word_t cw;
	seq_flags_t flags;

	logic accept;
	logic home_done;
	logic [IDX_W-1:0] home;
	logic probe_done;
	logic clear_last;
	logic [STAT_W-1:0] res_status;
	logic [POS_W-1:0] res_position;

	logic out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [POS_W-1:0] position_q;
	logic out_free;
	logic out_load;

	assign in_ready = cw.in_rdy;
	assign accept = in_valid && cw.in_rdy;

	// output register frees when empty or being taken this cycle
	assign out_free = !out_valid_q || out_ready;
	assign out_load = cw.res_load && out_free;

	assign flags.in_valid = in_valid;
	assign flags.home_done = home_done;
	assign flags.probe_done = probe_done;
	assign flags.out_free = out_free;
	assign flags.clear_last = clear_last;

	lph_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.flags(flags),
		.cw(cw)
	);

	// home slot = key mod SLOT_COUNT
	lph_home #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_home (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.run(cw.home_run),
		.key(key),
		.done(home_done),
		.home(home)
	);

	// slot memory and probe loop
	lph_dp #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cw(cw),
		.accept(accept),
		.mode(mode),
		.key(key),
		.home(home),
		.probe_done(probe_done),
		.clear_last(clear_last),
		.res_status(res_status),
		.res_position(res_position)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status;
			position_q <= res_position;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign position = position_q;

endmodule
